### hw/rtl/hbss_pkg.sv
// Shared types, constants and bit-scan functions for the hierarchical bitset.
// No dependencies; used by the top level of the block and by its checker.
package hbss_pkg;

  // Universe size is fixed by the 13-bit value and 12-bit position fields.
  localparam int unsigned UNIVERSE   = 4096;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEAF_WORDS = UNIVERSE / WORD_W;
  localparam int unsigned LEAF_AW    = $clog2(LEAF_WORDS);

  // Operation codes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_PREV   = 3'd4;
  localparam logic [2:0] OP_FILL   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [12:0] value;
  } hbss_req_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] position;
    logic [12:0] member_count;
    logic        range_error;
  } hbss_rsp_t;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [5:0] low_bit(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 63; i >= 0; i--) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [5:0] high_bit(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

### hw/rtl/hierarchical_bitset_successor_set.sv
// Top level of the hierarchical bitset: request sequencer, leaf RAM, summary word.
// Depends on hbss_pkg and hbss_ram.
//
// A word is taken when start is high and busy is low; its result appears on
// out_word for one cycle with out_valid and cannot be held off. Insert, delete
// and member test make one leaf RAM read, then the update; a search that stays
// in the starting leaf word does the same, one that moves to another leaf word
// makes a second leaf RAM read. An out-of-range request other than fill, or an
// undefined operation, answers from idle without a RAM read. Fill writes every
// one of the 64 leaf words through the RAM's single write port. Leaf words
// start empty after reset through per-word valid bits, so no clearing pass is
// needed and the block is ready right after reset.
module hierarchical_bitset_successor_set
  import hbss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  hbss_req_t in_word,
  output logic      out_valid,
  output hbss_rsp_t out_word
);

  typedef enum logic [1:0] {S_IDLE, S_LEAF, S_SCAN, S_FILL} state_t;

  state_t                  state_r;
  logic [2:0]              op_r;
  logic [11:0]             val_r;
  logic [12:0]             fill_n_r;
  logic [LEAF_AW-1:0]      idx_r;
  logic [LEAF_AW-1:0]      li_r;
  logic [63:0]             summary_r;
  logic [12:0]             count_r;
  logic [LEAF_WORDS-1:0]   valid_r;
  logic                    rvalid_r;
  logic                    out_valid_r;
  hbss_rsp_t               out_r;

  logic                    ram_we;
  logic [LEAF_AW-1:0]      ram_waddr;
  logic [63:0]             ram_wdata;
  logic [LEAF_AW-1:0]      ram_raddr;
  logic [63:0]             ram_rdata;

  logic [63:0] word;
  logic [5:0]  bsel;
  logic [5:0]  wsel;
  logic [63:0] bit_m;
  logic        present;
  logic [63:0] up_m;
  logic [63:0] dn_m;
  logic [63:0] sum_up;
  logic [63:0] sum_dn;
  logic [5:0]  li_nxt;
  logic [63:0] fill_word;
  logic [12:0] acc_n;
  logic [6:0]  acc_k;
  logic [63:0] acc_summary;

  hbss_ram #(.WIDTH(WORD_W), .DEPTH(LEAF_WORDS)) u_leaf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Leaf word just read; a word never written reads as empty.
  assign word    = rvalid_r ? ram_rdata : '0;
  assign bsel    = val_r[5:0];
  assign wsel    = val_r[11:6];
  assign bit_m   = 64'd1 << bsel;
  assign present = |(word & bit_m);
  assign up_m    = word & (~64'd0 << bsel);
  assign dn_m    = word & ~((~64'd0 << bsel) << 1);
  assign sum_up  = summary_r & ((~64'd0 << wsel) << 1);
  assign sum_dn  = summary_r & ~(~64'd0 << wsel);
  assign li_nxt  = (op_r == OP_NEXT) ? low_bit(sum_up) : high_bit(sum_dn);

  // Fill pattern of the leaf word under the sweep index.
  always_comb begin
    if ({1'b0, idx_r} < fill_n_r[12:6]) fill_word = ~64'd0;
    else if ({1'b0, idx_r} == fill_n_r[12:6]) fill_word = ~(~64'd0 << fill_n_r[5:0]);
    else fill_word = '0;
  end

  // Saturated fill count and the summary word it leaves.
  assign acc_n       = (in_word.value > 13'(UNIVERSE)) ? 13'(UNIVERSE) : in_word.value;
  assign acc_k       = 7'((acc_n + 13'd63) >> 6);
  assign acc_summary = acc_k[6] ? ~64'd0 : ~(~64'd0 << acc_k[5:0]);

  // RAM port control.
  always_comb begin
    ram_raddr = (state_r == S_IDLE) ? in_word.value[11:6] : li_nxt;
    ram_we    = 1'b0;
    ram_waddr = wsel;
    ram_wdata = word | bit_m;
    case (state_r)
      S_LEAF: begin
        if (op_r == OP_INSERT && !present) begin
          ram_we = 1'b1;
        end else if (op_r == OP_DELETE && present) begin
          ram_we    = 1'b1;
          ram_wdata = word & ~bit_m;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = fill_word;
      end
      default: ;
    endcase
  end

  // Sequencer, state and registered results.
  always_ff @(posedge clk) begin
    rvalid_r <= valid_r[ram_raddr];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      summary_r   <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (ram_we) valid_r[ram_waddr] <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_word.operation;
            val_r    <= in_word.value[11:0];
            out_r    <= '{hit: 1'b0, position: '0, member_count: count_r, range_error: 1'b0};
            if (in_word.operation <= OP_PREV) begin
              if (in_word.value[12]) begin
                out_r.range_error <= 1'b1;
                out_valid_r       <= 1'b1;
              end else begin
                state_r <= S_LEAF;
              end
            end else if (in_word.operation == OP_FILL) begin
              fill_n_r          <= acc_n;
              summary_r         <= acc_summary;
              out_r.range_error <= in_word.value > 13'(UNIVERSE);
              idx_r             <= '0;
              state_r           <= S_FILL;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_LEAF: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (!present) begin
                summary_r[wsel]    <= 1'b1;
                count_r            <= count_r + 13'd1;
                out_r.member_count <= count_r + 13'd1;
                out_r.hit          <= 1'b1;
              end
            end
            OP_DELETE: begin
              if (present) begin
                if ((word & ~bit_m) == '0) summary_r[wsel] <= 1'b0;
                count_r            <= count_r - 13'd1;
                out_r.member_count <= count_r - 13'd1;
                out_r.hit          <= 1'b1;
              end
            end
            OP_TEST: out_r.hit <= present;
            OP_NEXT: begin
              if (up_m != '0) begin
                out_r.hit      <= 1'b1;
                out_r.position <= {wsel, low_bit(up_m)};
              end else if (sum_up != '0) begin
                li_r        <= li_nxt;
                out_valid_r <= 1'b0;
                state_r     <= S_SCAN;
              end
            end
            default: begin
              if (dn_m != '0) begin
                out_r.hit      <= 1'b1;
                out_r.position <= {wsel, high_bit(dn_m)};
              end else if (sum_dn != '0) begin
                li_r        <= li_nxt;
                out_valid_r <= 1'b0;
                state_r     <= S_SCAN;
              end
            end
          endcase
        end
        S_SCAN: begin
          // Leaf word picked from the summary is non-empty by construction.
          out_r.hit      <= 1'b1;
          out_r.position <= {li_r, (op_r == OP_NEXT) ? low_bit(word) : high_bit(word)};
          out_valid_r    <= 1'b1;
          state_r        <= S_IDLE;
        end
        S_FILL: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LEAF_AW'(LEAF_WORDS - 1)) begin
            count_r            <= fill_n_r;
            out_r.member_count <= fill_n_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### hw/rtl/hbss_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hbss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hbss_checker.sv
// Port-level checker for the hierarchical bitset, bound to the top level.
// Depends on hbss_pkg and hierarchical_bitset_successor_set.
module hbss_checker
  import hbss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input hbss_rsp_t out_word
);

  // A taken word either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted word neither answered nor pending");

  // The member count never exceeds the universe.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.member_count <= 13'(UNIVERSE))
    else $error("member count beyond universe");

  // A miss reports position zero.
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.hit |-> out_word.position == '0)
    else $error("nonzero position without hit");

  // A rejected request never reports a hit.
  a_error_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.range_error |-> !out_word.hit)
    else $error("hit together with range error");

  // Reset leaves the block idle and silent.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind hierarchical_bitset_successor_set hbss_checker u_hbss_checker (.*);
